// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of the address parser.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while reset is released.
`define ASSERT_ACTIVE(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed while active");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/mactp_pkg.sv =====
// Package of the MAC address text parser: widths, character codes, types.
// No dependencies; imported by every file of the block but assert_macros.svh.
package mactp_pkg;

    localparam int ADDRESS_BYTES = 6;
    localparam int ADDR_W        = ADDRESS_BYTES * 8;
    localparam int COLL_W        = (ADDRESS_BYTES - 1) * 8;
    localparam int OUT_W         = 48;
    localparam int CHAR_W        = 8;
    localparam int IDX_W         = 3;
    localparam int DIGIT_W       = 4;

    localparam logic [IDX_W-1:0]  LAST_FIELD = IDX_W'(ADDRESS_BYTES - 1);
    localparam logic [7:0]        FIELD_MAX  = 8'hff;

    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3a;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;

    typedef struct packed {
        logic               is_hex;
        logic [DIGIT_W-1:0] digit;
        logic               is_colon;
        logic               is_nul;
    } t_char_class;

endpackage

// ===== rtl/mactp_if.sv =====
// Request channels of the MAC address text parser: characters in, results out.
// Depends on mactp_pkg for the payload widths.
interface mactp_char_if import mactp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface mactp_addr_if import mactp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] address;
    logic             ok;

    modport source (output valid, output address, output ok, input ready);
    modport sink   (input valid, input address, input ok, output ready);
endinterface

// ===== rtl/mactp_char_decode.sv =====
// Character classifier: hex digit value, colon and NUL detection.
// Depends on mactp_pkg.
module mactp_char_decode import mactp_pkg::*; (
    input  logic [CHAR_W-1:0] i_char,
    output t_char_class       o_class
);

    always_comb begin
        o_class.is_hex   = 1'b0;
        o_class.digit    = '0;
        o_class.is_colon = (i_char == CHAR_COLON);
        o_class.is_nul   = (i_char == CHAR_NUL);
        if (i_char >= CHAR_ZERO && i_char <= CHAR_NINE) begin
            o_class.is_hex = 1'b1;
            o_class.digit  = DIGIT_W'(i_char - CHAR_ZERO);
        end else if (i_char >= CHAR_LOWER_A && i_char <= CHAR_LOWER_F) begin
            o_class.is_hex = 1'b1;
            o_class.digit  = DIGIT_W'(i_char - CHAR_LOWER_A + 8'd10);
        end else if (i_char >= CHAR_UPPER_A && i_char <= CHAR_UPPER_F) begin
            o_class.is_hex = 1'b1;
            o_class.digit  = DIGIT_W'(i_char - CHAR_UPPER_A + 8'd10);
        end
    end

endmodule

// ===== rtl/mac_address_text_parser.sv =====
// Parses colon-separated hex address text, one character per request, and
// emits one result per parse: the stored address and a success flag. A
// character is accepted every cycle while the result side keeps up; each
// one passes an input register, then one update of the parse state, and its
// result, if any, is loaded into the output register with that update.
// Depends on mactp_pkg, mactp_if and mactp_char_decode.
module mac_address_text_parser import mactp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mactp_char_if.sink   i_char,
    mactp_addr_if.source o_addr
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;

    logic [IDX_W-1:0]  r_field_index, n_field_index;
    logic [7:0]        r_field_value, n_field_value;
    logic              r_too_big, n_too_big;
    logic [COLL_W-1:0] r_collected, n_collected;
    logic              r_wait, n_wait;
    logic [ADDR_W-1:0] r_stored, n_stored;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_addr;
    logic              r_out_ok;

    t_char_class       char_class;
    logic              advance;
    logic              step;
    logic              emit;
    logic              emit_ok;
    logic [11:0]       next_value;

    mactp_char_decode u_decode (
        .i_char  (r_char),
        .o_class (char_class)
    );

    assign advance      = !r_out_valid || o_addr.ready;
    assign step         = r_in_valid && advance;
    assign i_char.ready = !r_in_valid || advance;
    assign next_value   = {r_field_value, char_class.digit};

    always_comb begin
        n_field_index = r_field_index;
        n_field_value = r_field_value;
        n_too_big     = r_too_big;
        n_collected   = r_collected;
        n_wait        = r_wait;
        n_stored      = r_stored;
        emit          = 1'b0;
        emit_ok       = 1'b0;
        if (step) begin
            if (r_wait) begin
                if (char_class.is_nul) begin
                    n_wait = 1'b0;
                end
            end else if (char_class.is_hex) begin
                // Saturate at the field limit; the flag stays set for the whole parse.
                if (r_too_big || next_value[11:8] != 4'd0) begin
                    n_too_big     = 1'b1;
                    n_field_value = FIELD_MAX;
                end else begin
                    n_field_value = next_value[7:0];
                end
            end else if (r_field_index < LAST_FIELD && char_class.is_colon) begin
                n_collected   = (r_collected << 8) | COLL_W'(r_field_value);
                n_field_index = r_field_index + IDX_W'(1);
                n_field_value = '0;
            end else begin
                emit = 1'b1;
                if (r_field_index >= LAST_FIELD && !r_too_big) begin
                    emit_ok  = 1'b1;
                    n_stored = {r_collected, r_field_value};
                end
                n_field_index = '0;
                n_field_value = '0;
                n_too_big     = 1'b0;
                n_collected   = '0;
                n_wait        = !char_class.is_nul;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_field_index <= '0;
            r_field_value <= '0;
            r_too_big     <= 1'b0;
            r_collected   <= '0;
            r_wait        <= 1'b0;
            r_stored      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            r_field_index <= n_field_index;
            r_field_value <= n_field_value;
            r_too_big     <= n_too_big;
            r_collected   <= n_collected;
            r_wait        <= n_wait;
            r_stored      <= n_stored;
            if (advance) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_code;
        end
        if (emit) begin
            r_out_addr <= OUT_W'(n_stored);
            r_out_ok   <= emit_ok;
        end
    end

    assign o_addr.valid   = r_out_valid;
    assign o_addr.address = r_out_addr;
    assign o_addr.ok      = r_out_ok;

endmodule

// ===== rtl/mactp_checker.sv =====
// Port-level checks of the MAC address text parser, bound to the top level.
// Depends on mactp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mactp_checker import mactp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_out_address,
    input logic             i_out_ok
);

    // Address of the last successful result; a failed parse must report it unchanged.
    logic [OUT_W-1:0] r_last_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_addr <= '0;
        end else if (i_out_valid && i_out_ready && i_out_ok) begin
            r_last_addr <= i_out_address;
        end
    end

    `ASSERT_ALWAYS(a_reset_clears_result, i_clk, $past(!i_rst_n) |-> !i_out_valid)
    `ASSERT_ACTIVE(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `ASSERT_ACTIVE(a_fail_keeps_addr, i_clk, i_rst_n, i_out_valid && !i_out_ok |-> i_out_address == r_last_addr)

endmodule

bind mac_address_text_parser mactp_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_addr.valid),
    .i_out_ready   (o_addr.ready),
    .i_out_address (o_addr.address),
    .i_out_ok      (o_addr.ok)
);

// ===== tb/mactp_parse_checker.sv =====
// Checker for the MAC address text parser: predicts each parse result from the
// accepted characters and compares it with the results the block delivers.
// Depends on mactp_pkg and the request interfaces in mactp_if.
module mactp_parse_checker import mactp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mactp_char_if i_char,
    mactp_addr_if i_addr,
    output int    o_mismatches,
    output int    o_outstanding
);

    typedef struct packed {
        logic [OUT_W-1:0] address;
        logic             ok;
    } t_parse_result;

    t_parse_result        want_results[$];
    int                   mismatch_cnt;

    // Shadow copy of the parse state.
    logic [IDX_W-1:0]  cur_field;
    logic [7:0]        cur_value;
    logic              value_overflow;
    logic [COLL_W-1:0] done_bytes;
    logic              skip_to_nul;
    logic [ADDR_W-1:0] held_address;

    initial begin
        mismatch_cnt  = 0;
    end

    task automatic restart_parse();
        cur_field      = '0;
        cur_value      = '0;
        value_overflow = 1'b0;
        done_bytes     = '0;
        skip_to_nul    = 1'b0;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        logic [11:0]   shifted;
        logic [3:0]    digit;
        logic          is_digit;
        t_parse_result res;
        is_digit = 1'b1;
        digit    = '0;
        if (skip_to_nul) begin
            if (c == CHAR_NUL) restart_parse();
            return;
        end
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            digit = 4'(c - CHAR_ZERO);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            digit = 4'(c - CHAR_LOWER_A + 10);
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            digit = 4'(c - CHAR_UPPER_A + 10);
        end else begin
            is_digit = 1'b0;
        end
        if (is_digit) begin
            shifted = {cur_value, digit};
            // Once a field has overflowed it stays pinned at the maximum.
            if (value_overflow || shifted > 12'(FIELD_MAX)) begin
                value_overflow = 1'b1;
                cur_value      = FIELD_MAX;
            end else begin
                cur_value = shifted[7:0];
            end
            return;
        end
        if (cur_field < LAST_FIELD) begin
            if (c == CHAR_COLON) begin
                done_bytes = {done_bytes[COLL_W-9:0], cur_value};
                cur_field  = cur_field + 1'b1;
                cur_value  = '0;
                return;
            end
            res.ok = 1'b0;
        end else begin
            res.ok = !value_overflow;
            if (res.ok) held_address = {done_bytes, cur_value};
        end
        res.address = OUT_W'(held_address);
        want_results.push_back(res);
        restart_parse();
        skip_to_nul = (c != CHAR_NUL);
    endtask

    task automatic note_mismatch(input string what, input logic [OUT_W-1:0] exp_v,
                                 input logic [OUT_W-1:0] got_v);
        if (mismatch_cnt < 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_parse_result exp_r;
        if (!i_rst_n) begin
            restart_parse();
            held_address = '0;
            want_results.delete();
        end else begin
            if (i_addr.valid && i_addr.ready) begin
                if (want_results.size() == 0) begin
                    note_mismatch("unexpected result, address", '0, i_addr.address);
                end else begin
                    exp_r = want_results.pop_front();
                    if (i_addr.address !== exp_r.address)
                        note_mismatch("address", exp_r.address, i_addr.address);
                    if (i_addr.ok !== exp_r.ok)
                        note_mismatch("ok flag", OUT_W'(exp_r.ok), OUT_W'(i_addr.ok));
                end
            end
            if (i_char.valid && i_char.ready) parse_char(i_char.char_code);
        end
        o_outstanding <= want_results.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the MAC address text parser testbench: clock, reset, character
// stimulus and result back-pressure. Depends on mactp_pkg, mactp_if, the
// parser itself and mactp_parse_checker, which does all prediction.
module tb_top;
    import mactp_pkg::*;

    localparam int CHAR_TARGET = 1850;
    localparam int QUIET_AFTER = 1700;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    int   sent_chars;
    bit   quiet;
    bit   sender_bursts;

    mactp_char_if char_if ();
    mactp_addr_if addr_if ();

    mac_address_text_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_addr  (addr_if)
    );

    mactp_parse_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char        (char_if),
        .i_addr        (addr_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("mac_address_text_parser test failed");
        $finish;
    end

    function automatic logic [CHAR_W-1:0] hex_char(input int v, input bit upper);
        if (v < 10) return CHAR_ZERO + CHAR_W'(v);
        return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(v - 10);
    endfunction

    // A character that is neither a hex digit, a colon nor NUL.
    function automatic logic [CHAR_W-1:0] plain_char();
        case ($urandom_range(0, 3))
            0: return CHAR_W'($urandom_range(1, CHAR_ZERO - 1));
            1: return CHAR_W'($urandom_range(CHAR_COLON + 1, CHAR_UPPER_A - 1));
            2: return CHAR_W'($urandom_range(CHAR_UPPER_F + 1, CHAR_LOWER_A - 1));
            default: return CHAR_W'($urandom_range(CHAR_LOWER_F + 1, 255));
        endcase
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input bit counted);
        if (!quiet && sender_bursts && $urandom_range(0, 99) < 15) begin
            char_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        if (counted) sent_chars++;
    endtask

    task automatic send_text(input string s, input bit nul_end);
        for (int i = 0; i < s.len(); i++) send_char(CHAR_W'(s[i]), 1'b1);
        if (nul_end) send_char(CHAR_NUL, 1'b1);
    endtask

    task automatic drain_results();
        char_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic send_field();
        int  ndig;
        int  pick;
        bit  upper;
        pick  = $urandom_range(0, 99);
        upper = 1'($urandom_range(0, 1));
        if (pick < 10) ndig = 0;
        else if (pick < 80) ndig = $urandom_range(1, 2);
        else if (pick < 95) ndig = 3;
        else ndig = $urandom_range(4, 6);
        for (int i = 0; i < ndig; i++) begin
            // Leading zeros keep many long fields in range.
            if (ndig > 2 && i < ndig - 2 && $urandom_range(0, 1))
                send_char(CHAR_ZERO, 1'b1);
            else
                send_char(hex_char($urandom_range(0, 15), upper), 1'b1);
        end
    endtask

    // Ends a parse with a non-NUL character, trails some ignored text, then NUL.
    task automatic send_tail(input bit colon_ok);
        if (colon_ok && $urandom_range(0, 9) == 0) send_char(CHAR_COLON, 1'b1);
        else send_char(plain_char(), 1'b1);
        repeat ($urandom_range(0, 3)) send_char(CHAR_W'($urandom_range(1, 255)), 1'b1);
        send_char(CHAR_NUL, 1'b1);
    endtask

    task automatic send_sequence();
        int pick;
        int nf;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            for (int f = 0; f < ADDRESS_BYTES; f++) begin
                send_field();
                if (f < ADDRESS_BYTES - 1) send_char(CHAR_COLON, 1'b1);
            end
            if ($urandom_range(0, 1)) send_char(CHAR_NUL, 1'b1);
            else send_tail(1'b1);
        end else if (pick < 85) begin
            nf = $urandom_range(0, ADDRESS_BYTES - 2);
            for (int f = 0; f < nf; f++) begin
                send_field();
                send_char(CHAR_COLON, 1'b1);
            end
            send_field();
            if ($urandom_range(0, 99) < 40) send_char(CHAR_NUL, 1'b1);
            else send_tail(1'b0);
        end else begin
            repeat ($urandom_range(1, 8)) send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 1)) send_char(CHAR_NUL, 1'b1);
        end
    endtask

    // Result side: random stall bursts, none while the run is quiet.
    initial begin
        addr_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!quiet && sender_bursts && $urandom_range(0, 99) < 30) begin
                addr_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            addr_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    initial begin
        int next_drain;
        sent_chars        = 0;
        quiet             = 1'b0;
        sender_bursts     = 1'b1;
        next_drain        = 500;
        i_rst_n           <= 1'b0;
        char_if.valid     <= 1'b0;
        char_if.char_code <= CHAR_NUL;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty text fails at once.
        send_text("", 1'b1);
        // Mixed case, an empty field, last field ended by a non-NUL character.
        send_text("Ff:a0:9::B:c0/x", 1'b1);
        // Missing colon after the first field.
        send_text("1-", 1'b1);
        // Oversized last field keeps the stored address.
        send_text(":::::100", 1'b1);

        while (sent_chars < CHAR_TARGET) begin
            sender_bursts = ($urandom_range(0, 3) != 0);
            quiet         = (sent_chars > QUIET_AFTER);
            send_sequence();
            if (sent_chars >= next_drain) begin
                drain_results();
                next_drain += 500;
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("mac_address_text_parser test passed");
        end else begin
            $display("mac_address_text_parser test failed");
        end
        $finish;
    end

endmodule
